// ===== rtl/core/rjn_pkg.sv =====
`default_nettype none
package rjn_pkg;

    localparam int BLANK_DEPTH_DEF = 32;
    localparam int WIN             = 5;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQ     = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_V      = 8'h76;

    typedef enum logic [1:0] {Q_OUT, Q_DOUBLE, Q_SINGLE, Q_UNUSED} qmode_t;

    typedef enum logic [2:0] {
        B_IDLE, B_COMMA, B_PREF, B_BLANKS, B_BYTE, B_FIN, B_FIN_END
    } back_state_t;

    typedef enum logic [1:0] {TAIL_NONE, TAIL_BYTE, TAIL_FIN} tail_t;

    // One request from the front to the back: a byte, or the end of the text.
    typedef struct packed {
        logic       is_end;
        logic       last;
        logic [7:0] data;
    } tok_t;

    function automatic logic is_ident(input logic [7:0] b);
        return b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h5F};
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b inside {CH_SP, CH_TAB, CH_LF, CH_CR};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/relaxed_json_normalizer.sv =====
`default_nettype none
// Relaxed JSON to strict JSON, one text byte per request. The front holds a
// five-byte look-ahead window and rewrites quotes, comments, separators and the
// words void and nil; the back removes trailing commas, keeping up to
// BLANK_DEPTH blanks after a held comma in a small RAM. A four-entry queue sits
// between them. The first five bytes of a text are taken one per cycle; after
// that the front takes a new byte only once it has processed the window front,
// and a rewrite that yields several bytes (null, an escaped quote) pushes them
// into the queue one at a time. In the back a request that yields a byte is
// popped and then emitted before the next one is popped, and releasing a held
// comma emits the comma and then each stored blank. After the request marked
// as the end of the text, the window is drained with no new byte taken, and
// the last result carries out_end (a bare end marker with no_byte when the
// final request yields nothing). Results leave through a hold stage and an
// output register, so the last byte appears once the next one is known.
module relaxed_json_normalizer
    import rjn_pkg::*;
#(
    parameter int BLANK_DEPTH = BLANK_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_text_byte,
    input  wire logic       s_text_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_no_byte,
    output logic            m_out_end,
    output logic            m_blank_overflow
);
    logic q_push;
    tok_t q_in;
    logic q_full;
    logic q_pop;
    logic q_valid;
    tok_t q_out;

    rjn_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .s_text_end  (s_text_end),
        .tok_push    (q_push),
        .tok         (q_in),
        .q_full      (q_full)
    );

    rjn_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_tok (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_tok  (q_out)
    );

    rjn_back #(.BLANK_DEPTH(BLANK_DEPTH)) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .tok_valid        (q_valid),
        .tok              (q_out),
        .tok_pop          (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_no_byte        (m_no_byte),
        .m_out_end        (m_out_end),
        .m_blank_overflow (m_blank_overflow)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("request pushed into a full queue");

    a_marker_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_byte |-> m_out_end && m_out_byte == 8'h00)
        else $error("bare end marker without out_end");

    a_overflow_is_comma: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_blank_overflow |-> m_out_byte == CH_COMMA && !m_no_byte)
        else $error("overflow flag on a byte other than a comma");
endmodule
`default_nettype wire

// ===== rtl/core/rjn_ram.sv =====
`default_nettype none
module rjn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/rjn_queue.sv =====
`default_nettype none
module rjn_queue
    import rjn_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire tok_t push_tok,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output tok_t      pop_tok
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    tok_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign pop_tok = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/rjn_front.sv =====
`default_nettype none
module rjn_front
    import rjn_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_text_byte,
    input  wire logic       s_text_end,
    output logic            tok_push,
    output tok_t            tok,
    input  wire logic       q_full
);
    logic [7:0] win_reg [WIN];
    logic [2:0] fill_reg;
    qmode_t     qm_reg;
    logic       esc_reg;
    logic       com_reg;
    logic [7:0] prev_reg;
    logic       drain_reg;
    logic [1:0] ex_idx_reg;

    logic       proc_active;
    logic       accept;
    logic       end_push;
    logic       commit;
    logic [2:0] n_tok;
    logic [7:0] t [4];
    logic [2:0] used;
    qmode_t     qm_next;
    logic       esc_next;
    logic       com_next;
    logic       void_hit;
    logic       nil_hit;
    logic [7:0] c;

    assign proc_active = (fill_reg == 3'(WIN)) || (drain_reg && fill_reg != '0);
    assign s_ready     = !proc_active && !drain_reg;
    assign accept      = s_valid && s_ready;
    assign end_push    = drain_reg && fill_reg == '0 && !q_full;

    always_comb begin
        c = win_reg[0];
        void_hit = fill_reg >= 3'd4 && win_reg[0] == CH_V && win_reg[1] == CH_O
                && win_reg[2] == CH_I && win_reg[3] == CH_D && !is_ident(prev_reg)
                && (fill_reg == 3'd4 || !is_ident(win_reg[4]));
        nil_hit = fill_reg >= 3'd3 && win_reg[0] == CH_N && win_reg[1] == CH_I
                && win_reg[2] == CH_L && !is_ident(prev_reg)
                && (fill_reg == 3'd3 || !is_ident(win_reg[3]));
    end

    // Classify the window front: the bytes it turns into and how many raw bytes it takes.
    always_comb begin
        used     = 3'd1;
        n_tok    = 3'd0;
        t[0]     = c;
        t[1]     = c;
        t[2]     = c;
        t[3]     = c;
        qm_next  = qm_reg;
        esc_next = esc_reg;
        com_next = com_reg;
        if (com_reg) begin
            if (c == CH_LF || c == CH_CR) begin
                com_next = 1'b0;
                n_tok    = 3'd1;
            end
        end else if (qm_reg == Q_DOUBLE) begin
            n_tok = 3'd1;
            if (esc_reg) begin
                esc_next = 1'b0;
            end else if (c == CH_BSL) begin
                esc_next = 1'b1;
            end else if (c == CH_DQ) begin
                qm_next = Q_OUT;
            end
        end else if (qm_reg == Q_SINGLE) begin
            if (esc_reg) begin
                esc_next = 1'b0;
                if (c == CH_SQ) begin
                    n_tok = 3'd1;
                end else begin
                    n_tok = 3'd2;
                    t[0]  = CH_BSL;
                end
            end else if (c == CH_BSL) begin
                esc_next = 1'b1;
            end else if (c == CH_SQ) begin
                n_tok   = 3'd1;
                t[0]    = CH_DQ;
                qm_next = Q_OUT;
            end else if (c == CH_DQ) begin
                n_tok = 3'd2;
                t[0]  = CH_BSL;
            end else begin
                n_tok = 3'd1;
            end
        end else begin
            qm_next = Q_OUT;
            n_tok   = 3'd1;
            if (c == CH_DQ) begin
                qm_next  = Q_DOUBLE;
                esc_next = 1'b0;
            end else if (c == CH_SQ) begin
                qm_next  = Q_SINGLE;
                esc_next = 1'b0;
                t[0]     = CH_DQ;
            end else if (c == CH_HASH) begin
                com_next = 1'b1;
                n_tok    = 3'd0;
            end else if (c == CH_SEMI) begin
                t[0] = CH_COMMA;
            end else if (c == CH_EQ) begin
                t[0] = CH_COLON;
                if (fill_reg > 3'd1 && win_reg[1] == CH_GT) begin
                    used = 3'd2;
                end
            end else if (void_hit || nil_hit) begin
                used  = (c == CH_N) ? 3'd3 : 3'd4;
                n_tok = 3'd4;
                t[0]  = CH_N;
                t[1]  = CH_U;
                t[2]  = CH_L;
                t[3]  = CH_L;
            end
        end
        if (used > fill_reg) begin
            used = fill_reg;
        end
    end

    always_comb begin
        tok.is_end = end_push;
        tok.last   = drain_reg;
        tok.data   = end_push ? 8'h00 : t[ex_idx_reg];
        tok_push   = end_push || (proc_active && n_tok != '0 && !q_full);
        commit     = proc_active && (n_tok == '0
                     || (!q_full && {1'b0, ex_idx_reg} == n_tok - 3'd1));
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg[fill_reg] <= s_text_byte;
        end else if (commit) begin
            for (int i = 0; i < WIN; i++) begin
                if (i + int'(used) < WIN) begin
                    win_reg[i] <= win_reg[i + int'(used)];
                end
            end
        end
        if (!aresetn) begin
            fill_reg   <= '0;
            qm_reg     <= Q_OUT;
            esc_reg    <= 1'b0;
            com_reg    <= 1'b0;
            prev_reg   <= '0;
            drain_reg  <= 1'b0;
            ex_idx_reg <= '0;
        end else if (end_push) begin
            // The whole text is out: start the next one from the reset state.
            qm_reg    <= Q_OUT;
            esc_reg   <= 1'b0;
            com_reg   <= 1'b0;
            prev_reg  <= '0;
            drain_reg <= 1'b0;
        end else if (accept) begin
            fill_reg  <= fill_reg + 3'd1;
            drain_reg <= s_text_end;
        end else if (commit) begin
            fill_reg   <= fill_reg - used;
            qm_reg     <= qm_next;
            esc_reg    <= esc_next;
            com_reg    <= com_next;
            prev_reg   <= win_reg[used - 3'd1];
            ex_idx_reg <= '0;
        end else if (tok_push) begin
            ex_idx_reg <= ex_idx_reg + 2'd1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/rjn_back.sv =====
`default_nettype none
module rjn_back
    import rjn_pkg::*;
#(
    parameter int BLANK_DEPTH = BLANK_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       tok_valid,
    input  wire tok_t       tok,
    output logic            tok_pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_no_byte,
    output logic            m_out_end,
    output logic            m_blank_overflow
);
    localparam int AW = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;
    localparam int CW = $clog2(BLANK_DEPTH + 1);

    back_state_t state_reg, state_next;
    tok_t        cur_reg;
    tail_t       tail_reg;
    logic        ovf_reg;
    logic        in_str_reg;
    logic        esc_reg;
    logic        held_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] rel_cnt_reg;
    logic [AW-1:0] idx_reg;
    logic        any_reg;
    logic        hold_v_reg;
    logic [7:0]  hold_byte_reg;
    logic        hold_none_reg;
    logic        hold_ovf_reg;

    // Plan for the request at the queue head.
    back_state_t p_state;
    tail_t       p_tail;
    logic        p_ovf;
    logic        p_held;
    logic [CW-1:0] p_count;
    logic        p_write;

    logic        prod_v;
    logic [7:0]  prod_byte;
    logic        prod_none;
    logic        prod_ovf;
    logic        out_free;
    logic        prod_rdy;
    logic        fire;
    logic        blank_last;
    logic [AW-1:0] raddr;
    logic [7:0]  rdata;
    back_state_t tail_state;

    assign out_free   = !m_valid || m_ready;
    assign prod_rdy   = !hold_v_reg || out_free;
    assign fire       = prod_v && prod_rdy;
    assign blank_last = (CW'(idx_reg) == rel_cnt_reg - CW'(1));

    rjn_ram #(.WIDTH(8), .DEPTH(BLANK_DEPTH)) u_blank_ram (
        .aclk  (aclk),
        .we    (p_write && tok_pop),
        .waddr (count_reg[AW-1:0]),
        .wdata (tok.data),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        p_state = B_IDLE;
        p_tail  = TAIL_NONE;
        p_ovf   = 1'b0;
        p_held  = held_reg;
        p_count = count_reg;
        p_write = 1'b0;
        if (tok.is_end) begin
            p_state = held_reg ? B_COMMA : B_FIN;
            p_tail  = TAIL_FIN;
            p_held  = 1'b0;
            p_count = '0;
        end else if (in_str_reg) begin
            p_state = B_BYTE;
        end else if (held_reg) begin
            if (is_blank(tok.data)) begin
                if (count_reg == CW'(BLANK_DEPTH)) begin
                    p_state = B_COMMA;
                    p_tail  = TAIL_BYTE;
                    p_ovf   = 1'b1;
                    p_held  = 1'b0;
                    p_count = '0;
                end else begin
                    p_write = 1'b1;
                    p_count = count_reg + CW'(1);
                end
            end else if (tok.data == CH_RBRACE || tok.data == CH_RBRACK) begin
                // Trailing comma: drop it but keep the blanks.
                p_state = (count_reg == '0) ? B_BYTE : B_PREF;
                p_tail  = TAIL_BYTE;
                p_held  = 1'b0;
                p_count = '0;
            end else begin
                p_state = B_COMMA;
                p_held  = (tok.data == CH_COMMA);
                p_tail  = (tok.data == CH_COMMA) ? TAIL_NONE : TAIL_BYTE;
                p_count = '0;
            end
        end else if (tok.data == CH_COMMA) begin
            p_held  = 1'b1;
            p_count = '0;
        end else begin
            p_state = B_BYTE;
        end
    end

    always_comb begin
        case (tail_reg)
            TAIL_BYTE: tail_state = B_BYTE;
            TAIL_FIN:  tail_state = B_FIN;
            default:   tail_state = B_IDLE;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (tok_valid) begin
                    state_next = p_state;
                end
            end
            B_COMMA: begin
                if (fire) begin
                    state_next = (rel_cnt_reg == '0) ? tail_state : B_BLANKS;
                end
            end
            B_PREF: state_next = B_BLANKS;
            B_BLANKS: begin
                if (fire && blank_last) begin
                    state_next = tail_state;
                end
            end
            B_BYTE: begin
                if (fire) begin
                    state_next = B_IDLE;
                end
            end
            B_FIN: begin
                if (any_reg || fire) begin
                    state_next = B_FIN_END;
                end
            end
            B_FIN_END: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        tok_pop   = 1'b0;
        prod_v    = 1'b0;
        prod_byte = cur_reg.data;
        prod_none = 1'b0;
        prod_ovf  = 1'b0;
        raddr     = idx_reg;
        case (state_reg)
            B_IDLE: tok_pop = tok_valid;
            B_COMMA: begin
                prod_v    = 1'b1;
                prod_byte = CH_COMMA;
                prod_ovf  = ovf_reg;
                raddr     = '0;
            end
            B_PREF: raddr = '0;
            B_BLANKS: begin
                prod_v    = 1'b1;
                prod_byte = rdata;
                if (fire && !blank_last) begin
                    raddr = idx_reg + AW'(1);
                end
            end
            B_BYTE: prod_v = 1'b1;
            B_FIN: begin
                prod_v    = !any_reg;
                prod_byte = 8'h00;
                prod_none = 1'b1;
            end
            default: prod_v = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tok_pop) begin
            cur_reg     <= tok;
            tail_reg    <= p_tail;
            ovf_reg     <= p_ovf;
            rel_cnt_reg <= count_reg;
        end
        if (fire) begin
            hold_byte_reg <= prod_byte;
            hold_none_reg <= prod_none;
            hold_ovf_reg  <= prod_ovf;
        end
        if (fire && hold_v_reg) begin
            m_out_byte       <= hold_byte_reg;
            m_no_byte        <= hold_none_reg;
            m_blank_overflow <= hold_ovf_reg;
            m_out_end        <= 1'b0;
        end else if (state_reg == B_FIN_END && out_free) begin
            m_out_byte       <= hold_byte_reg;
            m_no_byte        <= hold_none_reg;
            m_blank_overflow <= hold_ovf_reg;
            m_out_end        <= 1'b1;
        end
        if (!aresetn) begin
            state_reg  <= B_IDLE;
            in_str_reg <= 1'b0;
            esc_reg    <= 1'b0;
            held_reg   <= 1'b0;
            count_reg  <= '0;
            idx_reg    <= '0;
            any_reg    <= 1'b0;
            hold_v_reg <= 1'b0;
            m_valid    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (tok_pop) begin
                held_reg  <= p_held;
                count_reg <= p_count;
                idx_reg   <= '0;
            end
            if (state_reg == B_BLANKS && fire && !blank_last) begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (state_reg == B_BYTE && fire) begin
                if (in_str_reg) begin
                    if (esc_reg) begin
                        esc_reg <= 1'b0;
                    end else if (cur_reg.data == CH_BSL) begin
                        esc_reg <= 1'b1;
                    end else if (cur_reg.data == CH_DQ) begin
                        in_str_reg <= 1'b0;
                    end
                end else if (cur_reg.data == CH_DQ) begin
                    in_str_reg <= 1'b1;
                end
            end
            if (fire && (cur_reg.last || state_reg == B_FIN)) begin
                any_reg <= 1'b1;
            end
            if (fire) begin
                hold_v_reg <= 1'b1;
            end
            if (fire && hold_v_reg) begin
                m_valid <= 1'b1;
            end else if (state_reg == B_FIN_END && out_free) begin
                m_valid    <= 1'b1;
                hold_v_reg <= 1'b0;
                in_str_reg <= 1'b0;
                esc_reg    <= 1'b0;
                held_reg   <= 1'b0;
                count_reg  <= '0;
                any_reg    <= 1'b0;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
module tb;
    import rjn_pkg::*;

    localparam int STORE_DEPTH = 32;
    localparam int STEP_LIMIT  = 48;
    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        logic [7:0] data;
        bit         none;
        bit         fin;
        bit         ovf;
    } norm_byte_t;

    // Mirrors the normalizer: a look-ahead front end feeding a trailing comma remover.
    class normalizer_scoreboard;
        qmode_t     qmode;
        bit         esc_pending, in_cmt;
        logic [7:0] prev_raw;
        logic [7:0] win[5];
        int         fill;
        bit         o_str, o_esc, comma_held;
        logic [7:0] blanks[STORE_DEPTH];
        int         nblank;
        norm_byte_t step_out[$];
        norm_byte_t awaited[$];
        int         errors, checked, overflows, texts;

        function new();
            errors = 0; checked = 0; overflows = 0; texts = 0;
            clear();
        endfunction

        function void clear();
            qmode = Q_OUT; esc_pending = 0; in_cmt = 0; prev_raw = 8'h00;
            fill = 0; o_str = 0; o_esc = 0; comma_held = 0; nblank = 0;
        endfunction

        function bit ident_char(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                   (b >= "0" && b <= "9") || b == "_";
        endfunction

        function bit blank_char(logic [7:0] b);
            return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR;
        endfunction

        function void put(logic [7:0] b, bit none, bit ovf);
            norm_byte_t r;
            if (step_out.size() >= STEP_LIMIT) return;
            r.data = b; r.none = none; r.fin = 0; r.ovf = ovf;
            if (ovf) overflows++;
            step_out = {step_out, r};
        endfunction

        function void release_comma(bit ovf);
            put(CH_COMMA, 0, ovf);
            for (int k = 0; k < nblank; k++) put(blanks[k], 0, 0);
            nblank = 0;
            comma_held = 0;
        endfunction

        function void trim_feed(logic [7:0] b);
            if (o_str) begin
                put(b, 0, 0);
                if (o_esc) o_esc = 0;
                else if (b == CH_BSL) o_esc = 1;
                else if (b == CH_DQ) o_str = 0;
                return;
            end
            if (comma_held) begin
                if (blank_char(b)) begin
                    if (nblank < STORE_DEPTH) begin
                        blanks[nblank] = b;
                        nblank++;
                    end else begin
                        release_comma(1);
                        put(b, 0, 0);
                    end
                    return;
                end
                if (b == CH_RBRACE || b == CH_RBRACK) begin
                    for (int k = 0; k < nblank; k++) put(blanks[k], 0, 0);
                    nblank = 0;
                    comma_held = 0;
                    put(b, 0, 0);
                    return;
                end
                release_comma(0);
            end
            if (b == CH_COMMA) begin
                comma_held = 1;
                nblank = 0;
                return;
            end
            if (b == CH_DQ) o_str = 1;
            put(b, 0, 0);
        endfunction

        function bit word_here(string w);
            int n;
            n = w.len();
            if (n > fill) return 0;
            for (int k = 0; k < n; k++)
                if (win[k] != w[k]) return 0;
            if (ident_char(prev_raw)) return 0;
            if (n < fill && ident_char(win[n])) return 0;
            return 1;
        endfunction

        function void front_byte();
            logic [7:0] c;
            int         used;
            c = win[0];
            used = 1;
            if (in_cmt) begin
                if (c == CH_LF || c == CH_CR) begin
                    in_cmt = 0;
                    trim_feed(c);
                end
            end else if (qmode == Q_DOUBLE) begin
                trim_feed(c);
                if (esc_pending) esc_pending = 0;
                else if (c == CH_BSL) esc_pending = 1;
                else if (c == CH_DQ) qmode = Q_OUT;
            end else if (qmode == Q_SINGLE) begin
                if (esc_pending) begin
                    if (c == CH_SQ) begin
                        trim_feed(CH_SQ);
                    end else begin
                        trim_feed(CH_BSL);
                        trim_feed(c);
                    end
                    esc_pending = 0;
                end else if (c == CH_BSL) begin
                    esc_pending = 1;
                end else if (c == CH_SQ) begin
                    trim_feed(CH_DQ);
                    qmode = Q_OUT;
                end else if (c == CH_DQ) begin
                    trim_feed(CH_BSL);
                    trim_feed(CH_DQ);
                end else begin
                    trim_feed(c);
                end
            end else begin
                qmode = Q_OUT;
                if (c == CH_DQ) begin
                    qmode = Q_DOUBLE; esc_pending = 0; trim_feed(c);
                end else if (c == CH_SQ) begin
                    qmode = Q_SINGLE; esc_pending = 0; trim_feed(CH_DQ);
                end else if (c == CH_HASH) begin
                    in_cmt = 1;
                end else if (c == CH_SEMI) begin
                    trim_feed(CH_COMMA);
                end else if (c == CH_EQ) begin
                    if (fill > 1 && win[1] == CH_GT) used = 2;
                    trim_feed(CH_COLON);
                end else if (word_here("void") || word_here("nil")) begin
                    used = (c == CH_N) ? 3 : 4;
                    trim_feed(CH_N); trim_feed(CH_U); trim_feed(CH_L); trim_feed(CH_L);
                end else begin
                    trim_feed(c);
                end
            end
            if (used > fill) used = fill;
            prev_raw = win[used-1];
            for (int k = 0; k + used < 5; k++) win[k] = win[k+used];
            fill -= used;
        endfunction

        function void note_request(logic [7:0] b, bit last);
            step_out.delete();
            while (fill >= 5) front_byte();
            win[fill] = b;
            fill++;
            while (fill >= 5) front_byte();
            if (last) begin
                while (fill > 0) front_byte();
                if (comma_held) release_comma(0);
                if (step_out.size() == 0) put(8'h00, 1, 0);
                step_out[step_out.size()-1].fin = 1;
                texts++;
                clear();
            end
            awaited = {awaited, step_out};
        endfunction

        task report(string msg);
            $display("MISMATCH after %0d results: %s", checked, msg);
            errors++;
        endtask

        task check_result(logic [7:0] data, logic none, logic fin, logic ovf);
            norm_byte_t e;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result byte %02h", data));
                return;
            end
            e = awaited.pop_front();
            if (data !== e.data)
                report($sformatf("out_byte %02h, expected %02h", data, e.data));
            if (none !== e.none)
                report($sformatf("no_byte %b, expected %b", none, e.none));
            if (fin !== e.fin)
                report($sformatf("out_end %b, expected %b", fin, e.fin));
            if (ovf !== e.ovf)
                report($sformatf("blank_overflow %b, expected %b", ovf, e.ovf));
            checked++;
        endtask
    endclass

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_valid = 0;
    logic       s_ready;
    logic [7:0] s_text_byte = 8'h00;
    logic       s_text_end = 0;
    logic       m_valid;
    logic       m_ready = 0;
    logic [7:0] m_out_byte;
    logic       m_no_byte, m_out_end, m_blank_overflow;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int requests = 0;
    int quiet = 0;
    normalizer_scoreboard sb = new();

    relaxed_json_normalizer DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_text_byte(s_text_byte), .s_text_end(s_text_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_byte(m_out_byte), .m_no_byte(m_no_byte),
        .m_out_end(m_out_end), .m_blank_overflow(m_blank_overflow)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_out_byte, m_no_byte, m_out_end, m_blank_overflow);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("relaxed_json_normalizer regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_request(logic [7:0] b, bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        s_text_end  <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(b, last);
        requests++;
    endtask

    task automatic send_text(ref logic [7:0] txt[$]);
        foreach (txt[i]) send_request(txt[i], i == txt.size() - 1);
    endtask

    task automatic add_str(ref logic [7:0] txt[$], input string s);
        for (int i = 0; i < s.len(); i++) txt = {txt, s[i]};
    endtask

    // Mostly well-formed fragments, with some raw noise and an occasional long blank run.
    task automatic build_text(ref logic [7:0] txt[$]);
        int pieces;
        txt.delete();
        pieces = $urandom_range(2, 8);
        repeat (pieces) begin
            case ($urandom_range(19))
                0:  add_str(txt, "{");
                1:  add_str(txt, "}");
                2:  add_str(txt, "[");
                3:  add_str(txt, "]");
                4:  add_str(txt, ", ");
                5:  add_str(txt, ";\n");
                6: begin
                    if ($urandom_range(1)) add_str(txt, "=");
                    else add_str(txt, "=>");
                end
                7: begin
                    if ($urandom_range(1)) add_str(txt, " void");
                    else add_str(txt, "nil ");
                end
                8: begin
                    if ($urandom_range(1)) add_str(txt, "voids");
                    else add_str(txt, "xnil");
                end
                9:  add_str(txt, "'a\\'b\"\\n'");
                10: add_str(txt, "\"q\\\"#,\"");
                11: add_str(txt, "# x,]\r");
                12: add_str(txt, "\t \n\r");
                13: add_str(txt, ",\t]");
                14: add_str(txt, "k_9:");
                15: add_str(txt, "'\\");
                16: begin
                    add_str(txt, ",");
                    repeat ($urandom_range(30, 36)) add_str(txt, $urandom_range(1) ? " " : "\n");
                    add_str(txt, $urandom_range(1) ? "}" : "x");
                end
                default: repeat ($urandom_range(1, 3)) txt = {txt, 8'($urandom_range(255))};
            endcase
        end
    endtask

    initial begin
        logic [7:0] txt[$];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed texts: a text that yields nothing, separators and words, an
        // unfinished single-quoted string ending on a backslash, extreme bytes.
        txt.delete(); add_str(txt, "#"); send_text(txt);
        txt.delete(); add_str(txt, "{a=>nil,\n}"); send_text(txt);
        txt.delete(); add_str(txt, "'\\'\"\\"); send_text(txt);
        txt.delete(); add_str(txt, "\"\\\"\""); send_text(txt);
        txt = {8'h00, 8'hFF}; add_str(txt, ";=v");
        send_text(txt);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 26 : 0;
            while (requests < 20 + 50 * (phase + 1)) begin
                build_text(txt);
                send_text(txt);
            end
        end
        s_valid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Sent %0d requests in %0d texts; checked %0d results, %0d with blank overflow.",
                 requests, sb.texts, sb.checked, sb.overflows);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("relaxed_json_normalizer regression: pass");
        end else begin
            $display("relaxed_json_normalizer regression: fail");
        end
        $finish;
    end
endmodule
